// ===== hdl/pqt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Process queue table package
// Command codes, status codes and default sizes that are shared by the files.
// ----------------------------------------------------------------------------
package pqt_pkg;

    // Field widths of the command and result words.
    localparam int KIND_W   = 3;
    localparam int NAME_W   = 64;
    localparam int CLASS_W  = 2;
    localparam int PRIO_W   = 4;
    localparam int SLOT_W   = 4;
    localparam int QSEL_W   = 2;
    localparam int STATUS_W = 3;

    // Default table size and the highest priority that set priority accepts.
    localparam int SLOTS_DEF        = 16;
    localparam int MAX_PRIORITY_DEF = 9;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE = 3'd0,
        KIND_FIND   = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_INSERT = 3'd3,
        KIND_SETPRI = 3'd4,
        KIND_FREE   = 3'd5,
        KIND_FRONT  = 3'd6,
        KIND_NEXT   = 3'd7
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_BAD_PRIO  = 3'd2,
        ST_FULL      = 3'd3,
        ST_QUEUED    = 3'd4
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/pqt_cmd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Process queue table command channel
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface pqt_cmd_if
    import pqt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [NAME_W-1:0]   name_tag;
    logic [CLASS_W-1:0]  proc_class;
    logic [PRIO_W-1:0]   prio;
    logic                exec_blocked;
    logic                susp_flag;
    logic [SLOT_W-1:0]   slot_in;
    logic [QSEL_W-1:0]   queue_sel;

    modport source (output valid, kind, name_tag, proc_class, prio, exec_blocked,
                    susp_flag, slot_in, queue_sel, input ready);
    modport sink   (input valid, kind, name_tag, proc_class, prio, exec_blocked,
                    susp_flag, slot_in, queue_sel, output ready);
endinterface

`default_nettype wire

// ===== hdl/pqt_res_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Process queue table result channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface pqt_res_if
    import pqt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic                slot_valid;
    logic [PRIO_W-1:0]   prio_out;
    logic [CLASS_W-1:0]  class_out;
    logic                blocked_out;
    logic                suspended_out;

    modport source (output valid, status, slot_out, slot_valid, prio_out, class_out,
                    blocked_out, suspended_out, input ready);
    modport sink   (input valid, status, slot_out, slot_valid, prio_out, class_out,
                    blocked_out, suspended_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/pqt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Process queue table RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

// ===== hdl/process_queue_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Process queue table
// Process entries linked into four queues, kept in one record RAM.
// ----------------------------------------------------------------------------
// One command word is taken at a time and answered by exactly one result word.
// Each entry record (name, class, priority, state and link) lives in a RAM with
// a registered read port; the allocated and queued marks and the four queue
// heads are flip-flops. Find and set priority walk the queues link by link;
// create, insert and set priority on a ready entry then walk the target queue to
// place the entry, and remove, free and set priority on a ready entry walk it to
// find the predecessor. The shortest commands are failures and free of an
// unqueued entry; the longest is set priority on a ready entry at the back of a
// long queue (search, unlink walk and link walk), as the walks over the linked
// list go through the RAM read port. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module process_queue_table
    import pqt_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int MAX_PRIORITY = MAX_PRIORITY_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    pqt_cmd_if.sink  cmd,
    pqt_res_if.source res
);
    localparam int SW = $clog2(SLOTS);
    localparam int LW = SW + 1;
    localparam logic [LW-1:0] NONE = LW'(SLOTS);

    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [CLASS_W-1:0] cls;
        logic [PRIO_W-1:0]  prio;
        logic               blk;
        logic               sus;
        logic [LW-1:0]      nxt;
    } rec_t;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_S, S_RD_SW, S_FD_STEP, S_FD_CHK,
        S_UL_START, S_UL_STEP, S_UL_CHK, S_UL_WPREV, S_UL_WSELF,
        S_LK_START, S_LK_STEP, S_LK_CHK, S_LK_WSELF, S_LK_WPREV,
        S_WR_S, S_RESP, S_OUT
    } state_t;

    state_t              state_reg;
    kind_t               kind_reg;
    logic [NAME_W-1:0]   name_reg;
    logic [PRIO_W-1:0]   prio_reg;
    logic                blk_reg;
    logic                sus_reg;
    logic [SW-1:0]       s_reg;
    logic [LW-1:0]       cur_reg;
    logic [SW-1:0]       prev_reg;
    logic                prev_none_reg;
    logic [1:0]          q_reg;
    rec_t                srec_reg;
    rec_t                prec_reg;
    logic [SLOTS-1:0]    alloc_reg;
    logic [SLOTS-1:0]    queued_reg;
    logic [LW-1:0]       head_reg [4];
    status_t             res_status_reg;
    logic                res_put_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic                out_slot_valid_reg;
    logic [PRIO_W-1:0]   out_prio_reg;
    logic [CLASS_W-1:0]  out_class_reg;
    logic                out_blk_reg;
    logic                out_sus_reg;

    // RAM port signals.
    logic                ram_we;
    logic [SW-1:0]       ram_waddr;
    rec_t                ram_wdata;
    logic [SW-1:0]       ram_raddr;
    rec_t                ram_rdata;

    // Decoded command fields.
    logic [SW-1:0]       slot_idx;
    logic                slot_ok;
    logic [SW-1:0]       free_idx;
    logic                full;
    logic                cur_none;
    logic [SW-1:0]       cur_idx;

    // Values taken when a command word is accepted.
    state_t              acc_state_next;
    logic [SW-1:0]       acc_slot_next;
    status_t             acc_status_next;

    pqt_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_idx = SW'(cmd.slot_in);
    assign slot_ok  = (int'(cmd.slot_in) < SLOTS) && alloc_reg[slot_idx];
    assign cur_none = (cur_reg >= NONE);
    assign cur_idx  = cur_reg[SW-1:0];

    // Lowest unallocated slot.
    always_comb
    begin
        free_idx = '0;
        full     = 1'b1;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!alloc_reg[i])
            begin
                free_idx = SW'(i);
                full     = 1'b0;
            end
        end
    end

    // First step, entry and status for a newly accepted command word.
    always_comb
    begin
        acc_state_next  = S_RD_S;
        acc_slot_next   = slot_idx;
        acc_status_next = ST_OK;
        case (kind_t'(cmd.kind))
            KIND_CREATE:
            begin
                if (full)
                begin
                    acc_status_next = ST_FULL;
                    acc_state_next  = S_RESP;
                end
                else
                begin
                    acc_slot_next  = free_idx;
                    acc_state_next = S_LK_START;
                end
            end
            KIND_FIND, KIND_SETPRI:
            begin
                acc_state_next = S_FD_STEP;
            end
            KIND_REMOVE, KIND_NEXT:
            begin
                if (!slot_ok || !queued_reg[slot_idx])
                begin
                    acc_status_next = ST_NOT_FOUND;
                    acc_state_next  = S_RESP;
                end
            end
            KIND_INSERT:
            begin
                if (!slot_ok)
                begin
                    acc_status_next = ST_NOT_FOUND;
                    acc_state_next  = S_RESP;
                end
                else if (queued_reg[slot_idx])
                begin
                    acc_status_next = ST_QUEUED;
                    acc_state_next  = S_RESP;
                end
            end
            KIND_FREE:
            begin
                if (!slot_ok)
                begin
                    acc_status_next = ST_NOT_FOUND;
                    acc_state_next  = S_RESP;
                end
                else if (!queued_reg[slot_idx])
                begin
                    acc_state_next = S_RESP;
                end
            end
            KIND_FRONT:
            begin
                acc_slot_next = head_reg[cmd.queue_sel][SW-1:0];
                if (head_reg[cmd.queue_sel] >= NONE)
                begin
                    acc_status_next = ST_NOT_FOUND;
                    acc_state_next  = S_RESP;
                end
            end
            default:
            begin
                acc_state_next = S_RESP;
            end
        endcase
    end

    // RAM reads and write-backs for each step of the sequencer.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = s_reg;
        ram_wdata = srec_reg;
        ram_raddr = cur_idx;
        case (state_reg)
            S_RD_S:
            begin
                ram_raddr = s_reg;
            end
            S_UL_WPREV:
            begin
                ram_we        = 1'b1;
                ram_waddr     = prev_reg;
                ram_wdata     = prec_reg;
                ram_wdata.nxt = srec_reg.nxt;
            end
            S_UL_WSELF:
            begin
                ram_we        = 1'b1;
                ram_wdata.nxt = NONE;
            end
            S_LK_WSELF:
            begin
                ram_we        = 1'b1;
                ram_wdata.nxt = cur_reg;
            end
            S_LK_WPREV:
            begin
                ram_we        = 1'b1;
                ram_waddr     = prev_reg;
                ram_wdata     = prec_reg;
                ram_wdata.nxt = LW'(s_reg);
            end
            S_WR_S:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign cmd.ready         = (state_reg == S_IDLE);
    assign res.valid         = out_valid_reg;
    assign res.status        = out_status_reg;
    assign res.slot_out      = out_slot_reg;
    assign res.slot_valid    = out_slot_valid_reg;
    assign res.prio_out      = out_prio_reg;
    assign res.class_out     = out_class_reg;
    assign res.blocked_out   = out_blk_reg;
    assign res.suspended_out = out_sus_reg;

    // Command sequencer with the marks, queue heads and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alloc_reg     <= '0;
            queued_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                head_reg[i] <= NONE;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        kind_reg       <= kind_t'(cmd.kind);
                        name_reg       <= cmd.name_tag;
                        prio_reg       <= cmd.prio;
                        blk_reg        <= cmd.exec_blocked;
                        sus_reg        <= cmd.susp_flag;
                        s_reg          <= acc_slot_next;
                        res_status_reg <= acc_status_next;
                        res_put_reg    <= 1'b0;
                        state_reg      <= acc_state_next;
                        case (kind_t'(cmd.kind))
                            KIND_CREATE:
                            begin
                                if (!full)
                                begin
                                    alloc_reg[free_idx] <= 1'b1;
                                    srec_reg            <= '{name: cmd.name_tag,
                                                             cls: cmd.proc_class,
                                                             prio: cmd.prio,
                                                             blk: 1'b0, sus: 1'b0,
                                                             nxt: NONE};
                                end
                            end
                            KIND_FIND, KIND_SETPRI:
                            begin
                                q_reg   <= 2'd0;
                                cur_reg <= head_reg[0];
                            end
                            KIND_FREE:
                            begin
                                if (slot_ok && !queued_reg[slot_idx])
                                begin
                                    alloc_reg[slot_idx] <= 1'b0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_RD_S:
                begin
                    state_reg <= S_RD_SW;
                end

                // The addressed record is back from the RAM.
                S_RD_SW:
                begin
                    case (kind_reg)
                        KIND_REMOVE, KIND_FREE:
                        begin
                            srec_reg  <= ram_rdata;
                            state_reg <= S_UL_START;
                        end
                        KIND_INSERT:
                        begin
                            srec_reg  <= {ram_rdata.name, ram_rdata.cls, ram_rdata.prio,
                                          blk_reg, sus_reg, ram_rdata.nxt};
                            state_reg <= S_LK_START;
                        end
                        KIND_NEXT:
                        begin
                            if (ram_rdata.nxt >= NONE)
                            begin
                                res_status_reg <= ST_NOT_FOUND;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                s_reg     <= ram_rdata.nxt[SW-1:0];
                                kind_reg  <= KIND_FRONT;
                                state_reg <= S_RD_S;
                            end
                        end
                        default:
                        begin
                            srec_reg    <= ram_rdata;
                            res_put_reg <= 1'b1;
                            state_reg   <= S_RESP;
                        end
                    endcase
                end

                // Name search over the four queues in turn.
                S_FD_STEP:
                begin
                    if (cur_none)
                    begin
                        if (q_reg == 2'd3)
                        begin
                            res_status_reg <= ST_NOT_FOUND;
                            state_reg      <= S_RESP;
                        end
                        else
                        begin
                            q_reg   <= q_reg + 2'd1;
                            cur_reg <= head_reg[q_reg + 2'd1];
                        end
                    end
                    else
                    begin
                        state_reg <= S_FD_CHK;
                    end
                end

                S_FD_CHK:
                begin
                    if (ram_rdata.name == name_reg)
                    begin
                        s_reg <= cur_idx;
                        if (kind_reg == KIND_FIND)
                        begin
                            srec_reg    <= ram_rdata;
                            res_put_reg <= 1'b1;
                            state_reg   <= S_RESP;
                        end
                        else if (int'(prio_reg) > MAX_PRIORITY)
                        begin
                            res_status_reg <= ST_BAD_PRIO;
                            state_reg      <= S_RESP;
                        end
                        else if (ram_rdata.blk)
                        begin
                            srec_reg  <= {ram_rdata.name, ram_rdata.cls, prio_reg,
                                          ram_rdata.blk, ram_rdata.sus, ram_rdata.nxt};
                            state_reg <= S_WR_S;
                        end
                        else
                        begin
                            srec_reg  <= ram_rdata;
                            state_reg <= S_UL_START;
                        end
                    end
                    else
                    begin
                        cur_reg   <= ram_rdata.nxt;
                        state_reg <= S_FD_STEP;
                    end
                end

                // Unlink: walk the entry's queue to find its predecessor.
                S_UL_START:
                begin
                    q_reg         <= {srec_reg.sus, srec_reg.blk};
                    cur_reg       <= head_reg[{srec_reg.sus, srec_reg.blk}];
                    prev_none_reg <= 1'b1;
                    state_reg     <= S_UL_STEP;
                end

                S_UL_STEP:
                begin
                    state_reg <= cur_none ? S_UL_WSELF : S_UL_CHK;
                end

                S_UL_CHK:
                begin
                    if (cur_idx == s_reg)
                    begin
                        if (prev_none_reg)
                        begin
                            head_reg[q_reg] <= srec_reg.nxt;
                            state_reg       <= S_UL_WSELF;
                        end
                        else
                        begin
                            state_reg <= S_UL_WPREV;
                        end
                    end
                    else
                    begin
                        prec_reg      <= ram_rdata;
                        prev_reg      <= cur_idx;
                        prev_none_reg <= 1'b0;
                        cur_reg       <= ram_rdata.nxt;
                        state_reg     <= S_UL_STEP;
                    end
                end

                S_UL_WPREV:
                begin
                    state_reg <= S_UL_WSELF;
                end

                S_UL_WSELF:
                begin
                    queued_reg[s_reg] <= 1'b0;
                    case (kind_reg)
                        KIND_FREE:
                        begin
                            srec_reg.nxt     <= NONE;
                            alloc_reg[s_reg] <= 1'b0;
                            state_reg        <= S_RESP;
                        end
                        KIND_SETPRI:
                        begin
                            srec_reg  <= {srec_reg.name, srec_reg.cls, prio_reg,
                                          srec_reg.blk, srec_reg.sus, NONE};
                            state_reg <= S_LK_START;
                        end
                        default:
                        begin
                            srec_reg.nxt <= NONE;
                            state_reg    <= S_RESP;
                        end
                    endcase
                end

                // Link: after equal priorities, or at the end if blocked.
                S_LK_START:
                begin
                    q_reg         <= {srec_reg.sus, srec_reg.blk};
                    cur_reg       <= head_reg[{srec_reg.sus, srec_reg.blk}];
                    prev_none_reg <= 1'b1;
                    state_reg     <= S_LK_STEP;
                end

                S_LK_STEP:
                begin
                    state_reg <= cur_none ? S_LK_WSELF : S_LK_CHK;
                end

                S_LK_CHK:
                begin
                    if (!srec_reg.blk && (ram_rdata.prio > srec_reg.prio))
                    begin
                        state_reg <= S_LK_WSELF;
                    end
                    else
                    begin
                        prec_reg      <= ram_rdata;
                        prev_reg      <= cur_idx;
                        prev_none_reg <= 1'b0;
                        cur_reg       <= ram_rdata.nxt;
                        state_reg     <= S_LK_STEP;
                    end
                end

                S_LK_WSELF:
                begin
                    srec_reg.nxt      <= cur_reg;
                    queued_reg[s_reg] <= 1'b1;
                    res_put_reg       <= (kind_reg != KIND_INSERT);
                    if (prev_none_reg)
                    begin
                        head_reg[q_reg] <= LW'(s_reg);
                        state_reg       <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_LK_WPREV;
                    end
                end

                S_LK_WPREV:
                begin
                    state_reg <= S_RESP;
                end

                S_WR_S:
                begin
                    res_put_reg <= 1'b1;
                    state_reg   <= S_RESP;
                end

                // Load the result word.
                S_RESP:
                begin
                    out_valid_reg      <= 1'b1;
                    out_status_reg     <= res_status_reg;
                    out_slot_valid_reg <= res_put_reg;
                    out_slot_reg       <= res_put_reg ? SLOT_W'(s_reg) : '0;
                    out_prio_reg       <= res_put_reg ? srec_reg.prio : '0;
                    out_class_reg      <= res_put_reg ? srec_reg.cls : '0;
                    out_blk_reg        <= res_put_reg & srec_reg.blk;
                    out_sus_reg        <= res_put_reg & srec_reg.sus;
                    state_reg          <= S_OUT;
                end

                S_OUT:
                begin
                    if (res.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

`default_nettype wire

// ===== verif/process_queue_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Process queue table testbench
// Drives command words with random bursts and gaps, predicts every result word
// from a behavioural copy of the table and its four queues, and compares each
// result word with the prediction while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module process_queue_table_tb;
    import pqt_pkg::*;

    localparam int NSLOT    = SLOTS_DEF;
    localparam int MAXPRI   = MAX_PRIORITY_DEF;
    localparam int NIL      = NSLOT;
    localparam int N_RANDOM = 1250;
    localparam int DRAIN    = 4 * NSLOT + 40;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] name_tag;
        logic [1:0]  proc_class;
        logic [3:0]  prio;
        logic        exec_blocked;
        logic        susp_flag;
        logic [3:0]  slot_in;
        logic [1:0]  queue_sel;
    } cmd_word_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] slot_out;
        logic       slot_valid;
        logic [3:0] prio_out;
        logic [1:0] class_out;
        logic       blocked_out;
        logic       suspended_out;
    } res_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pqt_cmd_if cmd ();
    pqt_res_if res ();

    process_queue_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .res   (res.source)
    );

    always #2 clk = ~clk;

    // Shadow table state.
    logic        tb_alloc  [NSLOT];
    logic        tb_queued [NSLOT];
    logic [63:0] tb_name   [NSLOT];
    logic [1:0]  tb_class  [NSLOT];
    logic [3:0]  tb_prio   [NSLOT];
    logic        tb_blk    [NSLOT];
    logic        tb_susp   [NSLOT];
    int          tb_link   [NSLOT];
    int          tb_head   [4];

    cmd_word_t pending_cmds[$];
    res_word_t expected_res[$];
    int        n_mismatch = 0;
    logic      stim_done = 1'b0;
    logic      hold_off = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        stall_phase = 0;

    function automatic int queue_index(int s);
        return (tb_susp[s] ? 2 : 0) + (tb_blk[s] ? 1 : 0);
    endfunction

    function automatic void unlink_slot(int s);
        int q;
        int prev;
        int cur;
        q = queue_index(s);
        prev = NIL;
        cur = tb_head[q];
        for (int n = 0; n < NSLOT && cur < NSLOT; n++)
        begin
            if (cur == s)
            begin
                if (prev == NIL)
                    tb_head[q] = tb_link[cur];
                else
                    tb_link[prev] = tb_link[cur];
                break;
            end
            prev = cur;
            cur = tb_link[cur];
        end
        tb_link[s] = NIL;
        tb_queued[s] = 1'b0;
    endfunction

    // Ready queues are ordered by priority, after equals; blocked queues are FIFO.
    function automatic void link_slot(int s);
        int q;
        int prev;
        int cur;
        q = queue_index(s);
        prev = NIL;
        cur = tb_head[q];
        for (int n = 0; n < NSLOT && cur < NSLOT; n++)
        begin
            if (!tb_blk[s] && tb_prio[cur] > tb_prio[s])
                break;
            prev = cur;
            cur = tb_link[cur];
        end
        tb_link[s] = cur;
        if (prev == NIL)
            tb_head[q] = s;
        else
            tb_link[prev] = s;
        tb_queued[s] = 1'b1;
    endfunction

    function automatic int search_name(logic [63:0] nm);
        int cur;
        for (int q = 0; q < 4; q++)
        begin
            cur = tb_head[q];
            for (int n = 0; n < NSLOT && cur < NSLOT; n++)
            begin
                if (tb_name[cur] == nm)
                    return cur;
                cur = tb_link[cur];
            end
        end
        return -1;
    endfunction

    function automatic res_word_t entry_word(int s);
        res_word_t r;
        r = '0;
        r.status = ST_OK;
        r.slot_out = s[3:0];
        r.slot_valid = 1'b1;
        r.prio_out = tb_prio[s];
        r.class_out = tb_class[s];
        r.blocked_out = tb_blk[s];
        r.suspended_out = tb_susp[s];
        return r;
    endfunction

    // Apply one command to the shadow table and return its result word.
    function automatic res_word_t table_outcome(cmd_word_t c);
        res_word_t r;
        int s;
        int f;
        int i;
        logic ok;
        r = '0;
        r.status = ST_OK;
        s = int'(c.slot_in);
        ok = tb_alloc[s];
        case (c.kind)
            KIND_CREATE:
            begin
                for (i = 0; i < NSLOT; i++)
                    if (!tb_alloc[i])
                        break;
                if (i >= NSLOT)
                    r.status = ST_FULL;
                else
                begin
                    tb_alloc[i] = 1'b1;
                    tb_name[i] = c.name_tag;
                    tb_class[i] = c.proc_class;
                    tb_prio[i] = c.prio;
                    tb_blk[i] = 1'b0;
                    tb_susp[i] = 1'b0;
                    link_slot(i);
                    r = entry_word(i);
                end
            end
            KIND_FIND:
            begin
                f = search_name(c.name_tag);
                if (f < 0)
                    r.status = ST_NOT_FOUND;
                else
                    r = entry_word(f);
            end
            KIND_REMOVE:
            begin
                if (!ok || !tb_queued[s])
                    r.status = ST_NOT_FOUND;
                else
                    unlink_slot(s);
            end
            KIND_INSERT:
            begin
                if (!ok)
                    r.status = ST_NOT_FOUND;
                else if (tb_queued[s])
                    r.status = ST_QUEUED;
                else
                begin
                    tb_blk[s] = c.exec_blocked;
                    tb_susp[s] = c.susp_flag;
                    link_slot(s);
                end
            end
            KIND_SETPRI:
            begin
                f = search_name(c.name_tag);
                if (f < 0)
                    r.status = ST_NOT_FOUND;
                else if (c.prio > MAXPRI)
                    r.status = ST_BAD_PRIO;
                else
                begin
                    if (!tb_blk[f])
                    begin
                        unlink_slot(f);
                        tb_prio[f] = c.prio;
                        link_slot(f);
                    end
                    else
                        tb_prio[f] = c.prio;
                    r = entry_word(f);
                end
            end
            KIND_FREE:
            begin
                if (!ok)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    if (tb_queued[s])
                        unlink_slot(s);
                    tb_alloc[s] = 1'b0;
                end
            end
            KIND_FRONT:
            begin
                if (tb_head[c.queue_sel] >= NSLOT)
                    r.status = ST_NOT_FOUND;
                else
                    r = entry_word(tb_head[c.queue_sel]);
            end
            default:
            begin
                if (!ok || !tb_queued[s] || tb_link[s] >= NSLOT)
                    r.status = ST_NOT_FOUND;
                else
                    r = entry_word(tb_link[s]);
            end
        endcase
        return r;
    endfunction

    // Names come from a small pool so that finds and duplicates hit often.
    function automatic logic [63:0] pick_name();
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return 64'd0;
            default: return {32'h5052_4F43, 24'd0, 8'($urandom_range(0, 11))};
        endcase
    endfunction

    function automatic cmd_word_t random_cmd();
        cmd_word_t c;
        int pick;
        c.name_tag = pick_name();
        c.proc_class = 2'($urandom_range(0, 3));
        c.prio = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(0, 9));
        c.exec_blocked = 1'($urandom_range(0, 1));
        c.susp_flag = 1'($urandom_range(0, 1));
        c.slot_in = 4'($urandom_range(0, 15));
        c.queue_sel = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 18)
            c.kind = KIND_CREATE;
        else if (pick < 30)
            c.kind = KIND_FIND;
        else if (pick < 42)
            c.kind = KIND_REMOVE;
        else if (pick < 56)
            c.kind = KIND_INSERT;
        else if (pick < 66)
            c.kind = KIND_SETPRI;
        else if (pick < 74)
            c.kind = KIND_FREE;
        else if (pick < 86)
            c.kind = KIND_FRONT;
        else
            c.kind = KIND_NEXT;
        return c;
    endfunction

    function automatic cmd_word_t make_cmd(kind_t k, logic [63:0] nm, int cls, int pr,
                                           int blk, int sus, int slot, int qs);
        cmd_word_t c;
        c.kind = k;
        c.name_tag = nm;
        c.proc_class = 2'(cls);
        c.prio = 4'(pr);
        c.exec_blocked = 1'(blk);
        c.susp_flag = 1'(sus);
        c.slot_in = 4'(slot);
        c.queue_sel = 2'(qs);
        return c;
    endfunction

    // Command driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            cmd.kind <= KIND_CREATE;
            cmd.name_tag <= '0;
            cmd.proc_class <= '0;
            cmd.prio <= '0;
            cmd.exec_blocked <= 1'b0;
            cmd.susp_flag <= 1'b0;
            cmd.slot_in <= '0;
            cmd.queue_sel <= '0;
        end
        else if (!cmd.valid || cmd.ready)
        begin
            if (cmd.valid && cmd.ready)
                expected_res.push_back(table_outcome(cmd_word_t'({cmd.kind, cmd.name_tag,
                    cmd.proc_class, cmd.prio, cmd.exec_blocked, cmd.susp_flag,
                    cmd.slot_in, cmd.queue_sel})));
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                cmd.valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0 && !hold_off)
            begin
                {cmd.kind, cmd.name_tag, cmd.proc_class, cmd.prio, cmd.exec_blocked,
                 cmd.susp_flag, cmd.slot_in, cmd.queue_sel} <= pending_cmds.pop_front();
                cmd.valid <= 1'b1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            else
                cmd.valid <= 1'b0;
        end
    end

    // Result monitor with its own stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        res_word_t got;
        res_word_t want;
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got = {status_t'(res.status), res.slot_out, res.slot_valid, res.prio_out,
                       res.class_out, res.blocked_out, res.suspended_out};
                if (expected_res.size() == 0)
                begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display("unexpected result word %h", got);
                end
                else
                begin
                    want = expected_res.pop_front();
                    if (got !== want)
                    begin
                        n_mismatch <= n_mismatch + 1;
                        if (n_mismatch < 10)
                            $display("result mismatch: expected %h got %h", want, got);
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 97;
            if (stall_phase < 30)
                res.ready <= 1'b1;
            else
                res.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    initial
    begin
        for (int i = 0; i < NSLOT; i++)
        begin
            tb_alloc[i] = 1'b0;
            tb_queued[i] = 1'b0;
            tb_name[i] = '0;
            tb_class[i] = '0;
            tb_prio[i] = '0;
            tb_blk[i] = 1'b0;
            tb_susp[i] = 1'b0;
            tb_link[i] = NIL;
        end
        for (int q = 0; q < 4; q++)
            tb_head[q] = NIL;

        // Directed part: empty table, equal priorities, every state, bad priority.
        pending_cmds.push_back(make_cmd(KIND_FRONT, 0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_NEXT, 0, 0, 0, 0, 0, 15, 0));
        pending_cmds.push_back(make_cmd(KIND_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_CREATE, 64'hFFFF_FFFF_FFFF_FFFF, 3, 15, 0, 0, 0,
                                        0));
        pending_cmds.push_back(make_cmd(KIND_CREATE, 64'd0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_CREATE, 64'hAAAA, 2, 5, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_CREATE, 64'hAAAA, 1, 5, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_NEXT, 0, 0, 0, 0, 0, 1, 0));
        pending_cmds.push_back(make_cmd(KIND_INSERT, 0, 0, 0, 1, 1, 2, 0));
        pending_cmds.push_back(make_cmd(KIND_REMOVE, 0, 0, 0, 0, 0, 2, 0));
        pending_cmds.push_back(make_cmd(KIND_INSERT, 0, 0, 0, 1, 1, 2, 0));
        pending_cmds.push_back(make_cmd(KIND_REMOVE, 0, 0, 0, 0, 0, 3, 0));
        pending_cmds.push_back(make_cmd(KIND_INSERT, 0, 0, 0, 0, 1, 3, 0));
        pending_cmds.push_back(make_cmd(KIND_REMOVE, 0, 0, 0, 0, 0, 1, 0));
        pending_cmds.push_back(make_cmd(KIND_INSERT, 0, 0, 0, 1, 0, 1, 0));
        pending_cmds.push_back(make_cmd(KIND_FIND, 64'hAAAA, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_SETPRI, 64'hAAAA, 0, 10, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_SETPRI, 64'hAAAA, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_SETPRI, 64'd0, 0, 9, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_SETPRI, 64'h1234, 0, 3, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_FRONT, 0, 0, 0, 0, 0, 0, 3));
        pending_cmds.push_back(make_cmd(KIND_FREE, 0, 0, 0, 0, 0, 3, 0));
        pending_cmds.push_back(make_cmd(KIND_FREE, 0, 0, 0, 0, 0, 3, 0));
        pending_cmds.push_back(make_cmd(KIND_INSERT, 0, 0, 0, 0, 0, 9, 0));
        for (int i = 0; i < NSLOT - 1; i++)
            pending_cmds.push_back(make_cmd(KIND_CREATE, 64'(i + 100), i, i, 0, 0, 0, 0));

        wait (rst_n);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                // Let the block drain completely once before carrying on.
                wait (pending_cmds.size() == 0);
                hold_off = 1'b1;
                @(posedge clk);
                wait (expected_res.size() == 0 && !cmd.valid);
                hold_off = 1'b0;
            end
            while (pending_cmds.size() > 8)
                @(posedge clk);
            pending_cmds.push_back(random_cmd());
        end
        wait (pending_cmds.size() == 0);
        @(posedge clk);
        wait (!cmd.valid);
        wait (expected_res.size() == 0);
        repeat (DRAIN) @(posedge clk);
        stim_done = 1'b1;
        if (n_mismatch == 0 && expected_res.size() == 0)
            $display("[process_queue_table] OK");
        else
            $display("[process_queue_table] ERROR");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #10_000_000;
        $display("[process_queue_table] ERROR");
        $finish;
    end

endmodule

// ===== process_queue_table.f =====
hdl/pqt_pkg.sv
hdl/pqt_cmd_if.sv
hdl/pqt_res_if.sv
hdl/pqt_ram.sv
hdl/process_queue_table.sv
verif/process_queue_table_tb.sv
